FILE: design/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// constants and types shared by the moving average block
// ----------------------------------------------------------------------------
package mavg_pkg;

	// window length and field widths
	localparam int WINDOW   = 10;
	localparam int SAMPLE_W = 14;
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int ITER_W   = $clog2(SUM_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_FINISH
	} state_t;

endpackage

FILE: design/moving_average_warmup_top.sv
// ----------------------------------------------------------------------------
// moving_average_warmup_top
// boxcar moving average with warm-up over signed temperature samples
// ----------------------------------------------------------------------------
// usage
//   input channel: sample with in_valid / in_ready; one transaction moves
//   one signed 14 bit sample in 1/16 degree units
//   output channel: average and window_full with out_valid / out_ready; one
//   result transaction follows each input transaction, in order
//   each sample replaces the oldest ring entry and updates the running sum;
//   the mean divides by the samples seen so far until the ring has filled
//   once, then by the full window, floor rounded
//   sequence: accept and update the sum, load the divider, run the shared
//   restoring divider at one quotient bit per cycle, then round and
//   register the result; in_ready is low from accept until the result is
//   registered
//   a registered result may wait for out_ready while the next sample is
//   accepted; a stalled receiver holds the block in its final step only
//   reset clears the ring, sum, write position and filled flag at once
// ----------------------------------------------------------------------------
module moving_average_warmup_top
	import mavg_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] average,
	output logic                       window_full
);

	// control state
	state_t             state_q, state_d;
	logic [ITER_W-1:0]  iter_q;
	logic [POS_W-1:0]   pos_q;
	logic               filled_q;
	logic               out_valid_q;

	// sample ring and running sum
	logic signed [SAMPLE_W-1:0] ring_q [WINDOW];
	logic signed [SUM_W-1:0]    sum_q;

	// divider operands
	logic [CNT_W-1:0]    den_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic                neg_q;
	logic signed [SAMPLE_W-1:0] avg_q;
	logic                full_q;

	// transaction strobes
	logic in_fire;
	logic out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// sum update for the accepted sample
	logic [CNT_W-1:0]        pos_inc;
	logic                    wrap;
	logic signed [SUM_W-1:0] sum_next;

	assign pos_inc  = CNT_W'(pos_q) + CNT_W'(1);
	assign wrap     = (pos_inc == CNT_W'(WINDOW));
	assign sum_next = sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(sample);

	// one restoring step: shift in the next dividend bit, subtract if it fits
	logic [CNT_W:0] shifted;
	logic           fits;
	logic [CNT_W:0] diff;

	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign fits    = (shifted >= {1'b0, den_q});
	assign diff    = shifted - {1'b0, den_q};

	// floor correction: a negative sum with a remainder rounds one further down
	logic [SUM_W-1:0] q_adj;
	logic [SUM_W-1:0] q_signed;

	assign q_adj    = quo_q + SUM_W'(neg_q && (rem_q != '0));
	assign q_signed = neg_q ? (~q_adj + SUM_W'(1)) : q_adj;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (iter_q == '0) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ring, sum, position and filled flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) ring_q[i] <= '0;
			sum_q    <= '0;
			pos_q    <= '0;
			filled_q <= 1'b0;
			den_q    <= '0;
		end else if (in_fire) begin
			ring_q[pos_q] <= sample;
			sum_q         <= sum_next;
			pos_q         <= wrap ? '0 : pos_inc[POS_W-1:0];
			if (wrap) filled_q <= 1'b1;
			den_q         <= (wrap || filled_q) ? CNT_W'(WINDOW) : pos_inc;
		end
	end

	// shared divider datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (state_q == ST_LOAD) begin
			iter_q <= ITER_W'(SUM_W - 1);
		end else if (state_q == ST_DIV) begin
			iter_q <= iter_q - ITER_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			neg_q <= sum_q[SUM_W-1];
			quo_q <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			avg_q  <= q_signed[SAMPLE_W-1:0];
			full_q <= filled_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign average     = avg_q;
	assign window_full = full_q;

	// checks on the sequencer and state
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("accepted a sample while the divider was busy");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(pos_q) < CNT_W'(WINDOW))
		else $error("write position beyond window");

	a_filled_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(filled_q) |-> filled_q)
		else $error("filled flag dropped");

	a_den_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != '0 && den_q <= CNT_W'(WINDOW)))
		else $error("divisor out of range");

endmodule
